### rtl/btlf_pkg.sv
package btlf_pkg;

    localparam int TIME_LEDS  = 20;
    localparam int IDX_W      = 6;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE = 1'b1;

    localparam logic [LEVEL_W-1:0] INTENSITY_RST = 8'd16;
    localparam logic [LEVEL_W-1:0] TEST_LEVEL    = 8'h10;
    localparam logic [4:0]         TEST_TICKS    = 5'd20;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;

    // last LED of the red (hours) and green (minutes) groups
    localparam logic [IDX_W-1:0] RED_LAST   = 6'd5;
    localparam logic [IDX_W-1:0] GREEN_LAST = 6'd12;

    typedef enum logic [1:0] {
        COL_NONE,
        COL_BLUE,
        COL_GREEN,
        COL_RED
    } t_colour;

    typedef struct packed {
        logic tick;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

    // binary 0..59 to packed BCD {tens, units}
    function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] units;
        if (v >= 6'd50) begin
            tens  = 4'd5;
            units = v - 6'd50;
        end else if (v >= 6'd40) begin
            tens  = 4'd4;
            units = v - 6'd40;
        end else if (v >= 6'd30) begin
            tens  = 4'd3;
            units = v - 6'd30;
        end else if (v >= 6'd20) begin
            tens  = 4'd2;
            units = v - 6'd20;
        end else if (v >= 6'd10) begin
            tens  = 4'd1;
            units = v - 6'd10;
        end else begin
            tens  = 4'd0;
            units = v;
        end
        return {tens, units[3:0]};
    endfunction

endpackage

### rtl/btlf_in_if.sv
interface btlf_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;

    modport source (
        output valid, hour_value, minute_value, second_value,
        input  ready
    );
    modport sink (
        input  valid, hour_value, minute_value, second_value,
        output ready
    );
endinterface

### rtl/btlf_out_if.sv
interface btlf_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_index;
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic [7:0] blue_level;
    logic       frame_end;

    modport source (
        output valid, led_index, green_level, red_level, blue_level, frame_end,
        input  ready
    );
    modport sink (
        input  valid, led_index, green_level, red_level, blue_level, frame_end,
        output ready
    );
endinterface

### rtl/btlf_ctrl.sv
module btlf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output btlf_pkg::t_dp_cmd  o_cmd,
    input  btlf_pkg::t_dp_sts  i_sts
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.tick = i_in_valid && (r_state == S_IDLE);
        o_cmd.load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_out_ready) r_out_valid <= 1'b0;
                    if (i_in_valid) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_cmd.load) begin
                        r_out_valid <= 1'b1;
                        if (i_sts.last) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/btlf_dp.sv
module btlf_dp #(
    parameter int unsigned LED_COUNT = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [btlf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [btlf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [4:0]                          i_hour_value,
    input  logic [5:0]                          i_minute_value,
    input  logic [5:0]                          i_second_value,
    input  btlf_pkg::t_dp_cmd                   i_cmd,
    output btlf_pkg::t_dp_sts                   o_sts,
    output logic [btlf_pkg::IDX_W-1:0]          o_led_index,
    output logic [btlf_pkg::LEVEL_W-1:0]        o_green_level,
    output logic [btlf_pkg::LEVEL_W-1:0]        o_red_level,
    output logic [btlf_pkg::LEVEL_W-1:0]        o_blue_level,
    output logic                                o_frame_end
);

    localparam logic [btlf_pkg::IDX_W-1:0] LAST_IDX = btlf_pkg::IDX_W'(LED_COUNT - 1);

    // Frame store, held compactly: one fill colour shared by every LED, and the
    // on/off pattern of the time LEDs with the level they were driven at.
    logic [btlf_pkg::LEVEL_W-1:0]   r_intensity;
    logic                           r_test_mode;
    logic                           r_was_test;
    logic [4:0]                     r_ticks;
    logic [1:0]                     r_phase;
    btlf_pkg::t_colour              r_base;
    logic                           r_driven;
    logic [btlf_pkg::LEVEL_W-1:0]   r_level;
    logic [btlf_pkg::TIME_LEDS-1:0] r_bits;
    logic [btlf_pkg::IDX_W-1:0]     r_idx;

    logic [4:0]                     n_ticks;
    logic [1:0]                     n_phase;
    btlf_pkg::t_colour              n_base;
    logic                           n_driven;
    logic [btlf_pkg::LEVEL_W-1:0]   n_level;
    logic [btlf_pkg::TIME_LEDS-1:0] n_bits;

    logic [4:0]                     w_hour;
    logic [5:0]                     w_minute;
    logic [5:0]                     w_second;
    logic [7:0]                     w_hour_bcd;
    logic [7:0]                     w_minute_bcd;
    logic [7:0]                     w_second_bcd;
    logic [4:0]                     w_ticks_inc;

    logic [btlf_pkg::TIME_LEDS-1:0] w_bits_sh;
    logic [btlf_pkg::LEVEL_W-1:0]   w_lit;
    logic [btlf_pkg::LEVEL_W-1:0]   w_green;
    logic [btlf_pkg::LEVEL_W-1:0]   w_red;
    logic [btlf_pkg::LEVEL_W-1:0]   w_blue;

    always_comb begin
        w_hour   = (i_hour_value > btlf_pkg::HOUR_MAX) ? btlf_pkg::HOUR_MAX : i_hour_value;
        w_minute = (i_minute_value > btlf_pkg::MINSEC_MAX) ? btlf_pkg::MINSEC_MAX
                                                           : i_minute_value;
        w_second = (i_second_value > btlf_pkg::MINSEC_MAX) ? btlf_pkg::MINSEC_MAX
                                                           : i_second_value;
        w_hour_bcd   = btlf_pkg::bin_to_bcd({1'b0, w_hour});
        w_minute_bcd = btlf_pkg::bin_to_bcd(w_minute);
        w_second_bcd = btlf_pkg::bin_to_bcd(w_second);
        w_ticks_inc  = r_ticks + 5'd1;

        n_ticks  = r_ticks;
        n_phase  = r_phase;
        n_base   = r_base;
        n_driven = r_driven;
        n_level  = r_level;
        n_bits   = r_bits;

        if (r_test_mode) begin
            if (w_ticks_inc >= btlf_pkg::TEST_TICKS) begin
                n_ticks  = 5'd0;
                n_driven = 1'b0;
                case (r_phase)
                    2'd0: begin
                        n_base  = btlf_pkg::COL_BLUE;
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        n_base  = btlf_pkg::COL_GREEN;
                        n_phase = 2'd2;
                    end
                    default: begin
                        n_base  = btlf_pkg::COL_RED;
                        n_phase = 2'd0;
                    end
                endcase
            end else begin
                n_ticks = w_ticks_inc;
            end
        end else begin
            // wipe the test colour on the first time tick after test mode
            if (r_was_test) n_base = btlf_pkg::COL_NONE;
            n_driven = 1'b1;
            n_level  = r_intensity;
            // LED 0 at the right end
            n_bits   = {w_second_bcd[3:0], w_second_bcd[6:4],
                        w_minute_bcd[3:0], w_minute_bcd[6:4],
                        w_hour_bcd[3:0],   w_hour_bcd[5:4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity <= btlf_pkg::INTENSITY_RST;
            r_test_mode <= 1'b0;
            r_was_test  <= 1'b0;
            r_ticks     <= 5'd0;
            r_phase     <= 2'd0;
            r_base      <= btlf_pkg::COL_NONE;
            r_driven    <= 1'b0;
            r_level     <= '0;
            r_bits      <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    btlf_pkg::REG_INTENSITY: begin
                        if (i_cfg_data != '0) r_intensity <= i_cfg_data;
                    end
                    btlf_pkg::REG_TEST_MODE: r_test_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.tick) begin
                r_ticks    <= n_ticks;
                r_phase    <= n_phase;
                r_base     <= n_base;
                r_driven   <= n_driven;
                r_level    <= n_level;
                r_bits     <= n_bits;
                r_was_test <= r_test_mode;
                r_idx      <= '0;
            end else if (i_cmd.load) begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    assign o_sts.last = (r_idx == LAST_IDX);

    // colour of the LED at r_idx
    always_comb begin
        w_bits_sh = r_bits >> r_idx;
        w_lit     = w_bits_sh[0] ? r_level : '0;
        w_green   = (r_base == btlf_pkg::COL_GREEN) ? btlf_pkg::TEST_LEVEL : '0;
        w_red     = (r_base == btlf_pkg::COL_RED)   ? btlf_pkg::TEST_LEVEL : '0;
        w_blue    = (r_base == btlf_pkg::COL_BLUE)  ? btlf_pkg::TEST_LEVEL : '0;
        if (r_driven && (r_idx < btlf_pkg::IDX_W'(btlf_pkg::TIME_LEDS))) begin
            if (r_idx <= btlf_pkg::RED_LAST) begin
                w_red = w_lit;
            end else if (r_idx <= btlf_pkg::GREEN_LAST) begin
                w_green = w_lit;
            end else begin
                w_blue = w_lit;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_led_index   <= r_idx;
            o_green_level <= w_green;
            o_red_level   <= w_red;
            o_blue_level  <= w_blue;
            o_frame_end   <= o_sts.last;
        end
    end

endmodule

### rtl/bcd_time_to_led_frame.sv
// A time item is taken while the block is idle; the controller then enters its
// emit state and loads the first LED beat into the output register; with a free
// sink the frame then streams one beat per cycle.
// No new item is taken until the last beat of the frame is loaded: the block takes
// the item and updates the store, then sends one beat per LED; a sink stall holds it.
// Reset (synchronous, active low): intensity 16, test mode off, LED store dark.
module bcd_time_to_led_frame #(
    parameter int unsigned LED_COUNT = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btlf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [btlf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    btlf_in_if.sink                           i_in,
    btlf_out_if.source                        o_out
);

    btlf_pkg::t_dp_cmd w_cmd;
    btlf_pkg::t_dp_sts w_sts;

    btlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    btlf_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_hour_value   (i_in.hour_value),
        .i_minute_value (i_in.minute_value),
        .i_second_value (i_in.second_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_led_index    (o_out.led_index),
        .o_green_level  (o_out.green_level),
        .o_red_level    (o_out.red_level),
        .o_blue_level   (o_out.blue_level),
        .o_frame_end    (o_out.frame_end)
    );

    // no new item while a frame is still streaming; the last beat may still wait
    a_busy_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.frame_end) |=>
        (!i_in.ready || o_out.frame_end))
        else $error("item taken in the middle of a frame");

    // beats of a frame come in string order without gaps
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.frame_end) |=>
        (o_out.valid && o_out.led_index == 6'($past(o_out.led_index) + 6'd1)))
        else $error("LED index did not advance by one");

    // frame end marks exactly the last LED
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        (o_out.frame_end == (o_out.led_index == btlf_pkg::IDX_W'(LED_COUNT - 1))))
        else $error("frame end flag misplaced");

    // a new item only starts when no beat but the last of the previous frame is pending
    a_clean_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!o_out.valid || o_out.frame_end))
        else $error("item taken with a frame pending");

endmodule
